[design/sbfd_pkg.sv]
// Shared types and constants of the SBUS frame decoder.
package sbfd_pkg;

	localparam int NumCh  = 16;
	localparam int ChW    = 11;
	localparam int AccW   = 18;
	localparam int PosW   = 5;
	localparam int BitsW  = 5;
	localparam int IdxW   = 4;

	localparam logic [7:0]      SyncByte      = 8'h0F;
	localparam logic [7:0]      ErrLimitReset = 8'd10;
	localparam logic [7:0]      CntMax        = 8'hFF;
	localparam logic [PosW-1:0] FirstDataPos  = 5'd1;
	localparam logic [PosW-1:0] LastDataPos   = 5'd22;
	localparam logic [PosW-1:0] FlagPos       = 5'd23;
	localparam logic [PosW-1:0] EmitPos       = 5'd24;
	localparam logic [PosW-1:0] FrameLen      = 5'd25;
	localparam logic [BitsW-1:0] ByteBits     = 5'd8;
	localparam logic [BitsW-1:0] ChBits       = 5'd11;
	localparam int LostBit     = 2;
	localparam int FailsafeBit = 3;

	typedef logic [ChW-1:0] sbfd_chan_t;

	// Control shared by every cell of the channel row.
	typedef struct packed {
		logic       load_good;
		logic       load_bad;
		logic       shift;
		sbfd_chan_t wr_data;
	} sbfd_cell_ctrl_t;

endpackage

[design/sbfd_if.sv]
// Valid/ready channel interfaces of the SBUS frame decoder.
interface sbfd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       frame_start;

	modport source (output valid, rx_byte, frame_start, input ready);
	modport sink (input valid, rx_byte, frame_start, output ready);
endinterface

interface sbfd_out_if;
	logic        valid;
	logic        ready;
	logic [3:0]  channel_index;
	logic [10:0] channel_value;
	logic        frame_ok;
	logic        signal_lost;
	logic        failsafe;
	logic        link_error;
	logic        last;

	modport source (output valid, channel_index, channel_value, frame_ok, signal_lost,
		failsafe, link_error, last, input ready);
	modport sink (input valid, channel_index, channel_value, frame_ok, signal_lost,
		failsafe, link_error, last, output ready);
endinterface

[design/sbfd_frame_decoder_core.sv]
// Top level of the SBUS frame decoder: byte unpacker and a row of channel cells.
// The input channel takes one received byte per transfer together with a frame start
// mark; the output channel gives the per-channel results of each completed frame.
// A good frame gives sixteen results, channels 0 to 15, with last on channel 15; a frame
// with a bad header gives one status result with last set. The error limit register is
// written through cfg_we and cfg_wdata; the user must write it only while no byte or
// result is in flight, which the block does not enforce. Bytes are accepted back to
// back, one per cycle while ready. The frame end byte loads the whole row of cells in
// the cycle it is accepted, so the first result is offered in the next cycle and the
// results leave at one per cycle while the receiver is ready. A frame is 25 bytes and
// yields at most 16 results, so an always ready receiver never holds up the input. When
// the receiver stalls, bytes are still taken until the next frame end byte, which waits
// until the row is empty, even while the previous frame's last result is transferred.
// Reset sets the byte position to 0, the error limit to 10, clears the counters and
// flags and empties the row; the first byte after reset is taken as a header even
// without the start mark.
module sbus_frame_decoder_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	sbfd_in_if.sink     in_ch,
	sbfd_out_if.source  out_ch
);
	import sbfd_pkg::*;

	logic [7:0]       error_limit_q;
	logic [PosW-1:0]  pos_q;
	logic             header_good_q;
	logic [AccW-1:0]  acc_q;
	logic [BitsW-1:0] bits_q;
	logic [IdxW-1:0]  ch_cnt_q;
	logic [7:0]       bad_cnt_q;
	logic             link_q;
	logic             lost_q;
	logic             fs_q;
	logic             snap_ok_q;
	logic             snap_lost_q;
	logic             snap_fs_q;
	logic             snap_link_q;
	logic [IdxW-1:0]  out_idx_q;

	logic             in_xfer;
	logic             out_xfer;
	logic [PosW-1:0]  eff_pos;
	logic             active;
	logic             is_header;
	logic             is_data;
	logic             is_flag;
	logic             emit;
	logic [AccW-1:0]  acc_sum;
	logic [BitsW-1:0] bits_sum;
	logic             ch_done;
	logic [7:0]       cnt_inc;
	sbfd_cell_ctrl_t  ctrl;
	logic [NumCh:0]   chain_valid;
	sbfd_chan_t       chain_value [NumCh+1];

	assign in_xfer  = in_ch.valid && in_ch.ready;
	assign out_xfer = out_ch.valid && out_ch.ready;

	// The row holds one frame of results; a new frame end waits until it has drained.
	assign in_ch.ready = !((pos_q == EmitPos) && chain_valid[0]);

	assign eff_pos   = in_ch.frame_start ? '0 : pos_q;
	assign active    = eff_pos < FrameLen;
	assign is_header = eff_pos == '0;
	assign is_data   = (eff_pos >= FirstDataPos) && (eff_pos <= LastDataPos);
	assign is_flag   = eff_pos == FlagPos;
	assign emit      = in_xfer && (eff_pos == EmitPos);

	// At most one channel completes per byte, since fewer than 11 bits are left over.
	assign acc_sum  = acc_q | ({{(AccW-8){1'b0}}, in_ch.rx_byte} << bits_q);
	assign bits_sum = bits_q + ByteBits;
	assign ch_done  = bits_sum >= ChBits;
	assign cnt_inc  = (bad_cnt_q == CntMax) ? bad_cnt_q : bad_cnt_q + 8'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_limit_q <= ErrLimitReset;
		end else if (cfg_we) begin
			error_limit_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q         <= '0;
			header_good_q <= 1'b0;
			acc_q         <= '0;
			bits_q        <= '0;
			ch_cnt_q      <= '0;
			bad_cnt_q     <= '0;
			link_q        <= 1'b0;
			lost_q        <= 1'b0;
			fs_q          <= 1'b0;
		end else if (in_xfer && active) begin
			pos_q <= eff_pos + 5'd1;
			if (is_header) begin
				acc_q    <= '0;
				bits_q   <= '0;
				ch_cnt_q <= '0;
				if (in_ch.rx_byte == SyncByte) begin
					header_good_q <= 1'b1;
					bad_cnt_q     <= '0;
					link_q        <= 1'b0;
				end else begin
					header_good_q <= 1'b0;
					bad_cnt_q     <= cnt_inc;
					if (cnt_inc > error_limit_q) begin
						link_q <= 1'b1;
					end
				end
			end else if (is_data) begin
				if (ch_done) begin
					acc_q    <= acc_sum >> ChW;
					bits_q   <= bits_sum - ChBits;
					ch_cnt_q <= ch_cnt_q + 4'd1;
				end else begin
					acc_q  <= acc_sum;
					bits_q <= bits_sum;
				end
			end else if (is_flag) begin
				if (header_good_q) begin
					lost_q <= in_ch.rx_byte[LostBit];
					fs_q   <= in_ch.rx_byte[FailsafeBit];
				end
			end
		end
	end

	// Status is captured at the frame end so the next frame cannot disturb the drain.
	always_ff @(posedge clk) begin
		if (emit) begin
			snap_ok_q   <= header_good_q;
			snap_lost_q <= lost_q;
			snap_fs_q   <= fs_q;
			snap_link_q <= link_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_idx_q <= '0;
		end else if (emit) begin
			out_idx_q <= '0;
		end else if (out_xfer) begin
			out_idx_q <= out_idx_q + 4'd1;
		end
	end

	assign ctrl.load_good = emit && header_good_q;
	assign ctrl.load_bad  = emit && !header_good_q;
	assign ctrl.shift     = out_xfer;
	assign ctrl.wr_data   = acc_sum[ChW-1:0];

	assign chain_valid[NumCh] = 1'b0;
	assign chain_value[NumCh] = '0;

	for (genvar i = 0; i < NumCh; i++) begin : g_cell
		logic store_we;

		assign store_we = in_xfer && is_data && header_good_q && ch_done
			&& (ch_cnt_q == IdxW'(i));

		sbfd_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.store_we   (store_we),
			.is_head    (1'(i == 0)),
			.nb_valid   (chain_valid[i+1]),
			.nb_value   (chain_value[i+1]),
			.slot_valid (chain_valid[i]),
			.slot_value (chain_value[i])
		);
	end

	assign out_ch.valid         = chain_valid[0];
	assign out_ch.channel_index = out_idx_q;
	assign out_ch.channel_value = chain_value[0];
	assign out_ch.frame_ok      = snap_ok_q;
	assign out_ch.signal_lost   = snap_lost_q;
	assign out_ch.failsafe      = snap_fs_q;
	assign out_ch.link_error    = snap_link_q;
	assign out_ch.last          = !chain_valid[1];

`ifndef ASSERT_OFF
	a_no_load_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> !chain_valid[0])
		else $error("frame end accepted while results still pending");

	a_frame_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && !out_ch.last) |=> out_ch.valid)
		else $error("result row emptied before its last result");

	a_bad_frame_single: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && !out_ch.frame_ok) |-> (out_ch.last && out_ch.channel_index == '0))
		else $error("bad frame status result is not a single last result");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= FrameLen)
		else $error("byte position beyond idle value");
`endif

endmodule

[design/sbfd_cell.sv]
// One channel cell: stored channel value plus one slot of the result shift row.
module sbfd_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  sbfd_pkg::sbfd_cell_ctrl_t ctrl,
	input  logic                      store_we,
	input  logic                      is_head,
	input  logic                      nb_valid,
	input  sbfd_pkg::sbfd_chan_t      nb_value,
	output logic                      slot_valid,
	output sbfd_pkg::sbfd_chan_t      slot_value
);
	import sbfd_pkg::*;

	sbfd_chan_t store_q;
	logic       slot_valid_q;
	sbfd_chan_t slot_value_q;

	always_ff @(posedge clk) begin
		if (store_we) begin
			store_q <= ctrl.wr_data;
		end
	end

	// A bad frame leaves a single zero result in the head cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= 1'b0;
		end else if (ctrl.load_good) begin
			slot_valid_q <= 1'b1;
		end else if (ctrl.load_bad) begin
			slot_valid_q <= is_head;
		end else if (ctrl.shift) begin
			slot_valid_q <= nb_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_good) begin
			slot_value_q <= store_q;
		end else if (ctrl.load_bad) begin
			slot_value_q <= '0;
		end else if (ctrl.shift) begin
			slot_value_q <= nb_value;
		end
	end

	assign slot_valid = slot_valid_q;
	assign slot_value = slot_value_q;

endmodule
